// File: design/ffba_pkg.sv
// shared types, codes and defaults for the first-fit block allocator
package ffba_pkg;

  localparam int unsigned MaxBlocksDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 16;
  localparam logic [31:0] HeapBytesReset     = 32'd65536;

  localparam logic ActionAlloc = 1'b0;
  localparam logic ActionFree  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_HEAP_FULL    = 2'd1,
    STATUS_TABLE_FULL   = 2'd2,
    STATUS_UNKNOWN_ADDR = 2'd3
  } status_e;

  // one row of the block table
  typedef struct packed {
    logic        avail;
    logic [31:0] offset;
    logic [31:0] length;
  } entry_t;

  // verdict of the compare unit on one table row
  typedef struct packed {
    logic        hit;
    logic [31:0] user_addr;
  } match_t;

endpackage

// File: design/first_fit_block_allocator_top.sv
// first-fit block allocator: table scan newest to oldest through one compare unit
// sequence: a request is taken only in S_IDLE; the scan reads rows from newest to oldest and stops
//   at the first hit; with no hit an allocate tries to take a new block at the bump pointer in S_BUMP;
//   with an empty table a free goes straight to S_FINISH and an allocate to S_BUMP
// throughput: input stalled until the result is loaded in S_FINISH, so one request at a time; the
//   result waits in S_FINISH while out_stall_i holds the previous result
// reset: asynchronous, clears table count and bump pointer, heap size 65536, rows not cleared
module first_fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        heap_bytes_we_i,
  input  logic [31:0] heap_bytes_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] release_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] user_address_o,
  output logic [1:0]  status_o,
  output logic        reused_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned ENT_W = $bits(ffba_pkg::entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_BUMP,
    S_FINISH
  } state_e;

  state_e                state_q;
  logic [31:0]           heap_q;
  logic [CNT_W-1:0]      count_q;
  logic [31:0]           bump_q;
  logic                  action_q;
  logic [31:0]           req_q;
  logic [31:0]           addr_q;
  logic [CNT_W-1:0]      idx_q;
  logic                  pend_q;
  logic [IDX_W-1:0]      pend_idx_q;
  logic [31:0]           res_addr_q;
  ffba_pkg::status_e     res_status_q;
  logic                  res_reused_q;
  logic                  out_valid_q;
  logic [31:0]           out_addr_q;
  ffba_pkg::status_e     out_status_q;
  logic                  out_reused_q;

  logic [CNT_W-1:0]      idx_dec;
  logic                  rd_en;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  ffba_pkg::entry_t      wr_entry;
  ffba_pkg::entry_t      rd_entry;
  logic [ENT_W-1:0]      rd_word;
  ffba_pkg::match_t      match;
  logic                  scan_hit;
  logic                  table_full;
  logic [33:0]           end_sum;
  logic                  heap_short;
  logic                  bump_ok;
  logic                  in_xfer;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign rd_entry = ffba_pkg::entry_t'(rd_word);

  ffba_match #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_match (
    .action_i         (action_q),
    .request_bytes_i  (req_q),
    .release_address_i(addr_q),
    .entry_i          (rd_entry),
    .match_o          (match)
  );

  always_comb begin
    idx_dec    = idx_q - CNT_W'(1);
    rd_en      = (state_q == S_SCAN) && (idx_q != '0);
    scan_hit   = (state_q == S_SCAN) && pend_q && match.hit;
    table_full = (count_q >= CNT_W'(MAX_BLOCKS));
    end_sum    = {2'b00, bump_q} + 34'(HEADER_BYTES) + {2'b00, req_q};
    heap_short = (end_sum > {2'b00, heap_q});
    bump_ok    = !table_full && !heap_short;
    wr_en      = scan_hit || ((state_q == S_BUMP) && bump_ok);
    if (scan_hit) begin
      wr_addr         = pend_idx_q;
      wr_entry.avail  = (action_q == ffba_pkg::ActionFree);
      wr_entry.offset = rd_entry.offset;
      wr_entry.length = rd_entry.length;
    end else begin
      wr_addr         = count_q[IDX_W-1:0];
      wr_entry.avail  = 1'b0;
      wr_entry.offset = bump_q;
      wr_entry.length = req_q;
    end
  end

  ffba_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(idx_dec[IDX_W-1:0]),
    .rdata_o(rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q      <= ffba_pkg::HeapBytesReset;
    end else if (heap_bytes_we_i) begin
      heap_q      <= heap_bytes_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      bump_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      action_q     <= ffba_pkg::ActionAlloc;
      req_q        <= '0;
      addr_q       <= '0;
      idx_q        <= '0;
      pend_idx_q   <= '0;
      res_addr_q   <= '0;
      res_status_q <= ffba_pkg::STATUS_OK;
      res_reused_q <= 1'b0;
      out_addr_q   <= '0;
      out_status_q <= ffba_pkg::STATUS_OK;
      out_reused_q <= 1'b0;
    end else begin
      // a result loaded in S_FINISH takes the place of the one leaving
      if (out_valid_q && !out_stall_i && (state_q != S_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            action_q     <= action_i;
            req_q        <= request_bytes_i;
            addr_q       <= release_address_i;
            idx_q        <= count_q;
            pend_q       <= 1'b0;
            res_addr_q   <= '0;
            res_status_q <= ffba_pkg::STATUS_UNKNOWN_ADDR;
            res_reused_q <= 1'b0;
            if (count_q != '0) begin
              state_q <= S_SCAN;
            end else if (action_i == ffba_pkg::ActionFree) begin
              state_q <= S_FINISH;
            end else begin
              state_q <= S_BUMP;
            end
          end
        end
        S_SCAN: begin
          // read of the next older row overlaps the compare of the current one
          pend_q     <= (idx_q != '0);
          pend_idx_q <= idx_dec[IDX_W-1:0];
          if (idx_q != '0) begin
            idx_q <= idx_dec;
          end
          if (scan_hit) begin
            res_status_q <= ffba_pkg::STATUS_OK;
            if (action_q == ffba_pkg::ActionFree) begin
              res_addr_q   <= '0;
              res_reused_q <= 1'b0;
            end else begin
              res_addr_q   <= match.user_addr;
              res_reused_q <= 1'b1;
            end
            state_q <= S_FINISH;
          end else if (pend_q && (idx_q == '0)) begin
            // oldest row checked without a hit
            state_q <= (action_q == ffba_pkg::ActionFree) ? S_FINISH : S_BUMP;
          end
        end
        S_BUMP: begin
          res_reused_q <= 1'b0;
          if (table_full) begin
            res_addr_q   <= '0;
            res_status_q <= ffba_pkg::STATUS_TABLE_FULL;
          end else if (heap_short) begin
            res_addr_q   <= '0;
            res_status_q <= ffba_pkg::STATUS_HEAP_FULL;
          end else begin
            res_addr_q   <= bump_q + 32'(HEADER_BYTES);
            res_status_q <= ffba_pkg::STATUS_OK;
            count_q      <= count_q + CNT_W'(1);
            bump_q       <= end_sum[31:0];
          end
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_reused_q <= res_reused_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign user_address_o = out_addr_q;
  assign status_o       = out_status_q;
  assign reused_o       = out_reused_q;

endmodule

// File: design/ffba_ram.sv
// generic single-write, single-read ram with registered read data
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ffba_match.sv
// compare unit: checks one table row against the pending request
module ffba_match #(
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDefault
) (
  input  logic              action_i,
  input  logic [31:0]       request_bytes_i,
  input  logic [31:0]       release_address_i,
  input  ffba_pkg::entry_t  entry_i,
  output ffba_pkg::match_t  match_o
);

  logic [32:0] user_addr_wide;
  logic        alloc_hit;
  logic        free_hit;

  // payload offset kept one bit wider so a wrapped sum never matches
  assign user_addr_wide = {1'b0, entry_i.offset} + 33'(HEADER_BYTES);
  assign alloc_hit      = entry_i.avail && (entry_i.length >= request_bytes_i);
  assign free_hit       = (user_addr_wide == {1'b0, release_address_i});

  always_comb begin
    match_o.user_addr = user_addr_wide[31:0];
    match_o.hit       = (action_i == ffba_pkg::ActionFree) ? free_hit : alloc_hit;
  end

endmodule

// File: design/ffba_checker.sv
// port-level checks for the first-fit block allocator, bound to the top level
module ffba_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] user_address_o,
  input logic [1:0]  status_o,
  input logic        reused_o
);

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(user_address_o)
      && $stable(status_o) && $stable(reused_o))
    else $error("stalled result changed");

  // failed requests hand out no address and reuse nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ffba_pkg::STATUS_OK) |-> (user_address_o == '0) && !reused_o)
    else $error("failed request carries an address or reuse mark");

  // a reused block always means a successful allocation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reused_o |-> (status_o == ffba_pkg::STATUS_OK))
    else $error("reuse reported with an error status");

  // the block is busy right after taking a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in progress");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);

// File: tb/ffba_checker.sv
// scoreboard for the first-fit block allocator: mirrors the block table and checks each result
`timescale 1ns / 1ps
module ffba_scoreboard #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        heap_bytes_we_i,
  input  logic [31:0] heap_bytes_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        action_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] release_address_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] user_address_i,
  input  logic [1:0]  status_i,
  input  logic        reused_i,
  output int          fail_count_o,
  output int          grants_due_o,
  output int          results_seen_o,
  output int          reuse_seen_o,
  output logic [3:0]  status_mask_o
);

  typedef struct packed {
    logic [31:0]       addr;
    ffba_pkg::status_e status;
    logic              reused;
  } grant_t;

  // mirror of the block table
  logic [31:0] blk_hdr  [MAX_BLOCKS];
  logic [31:0] blk_size [MAX_BLOCKS];
  logic        blk_free [MAX_BLOCKS];
  int          blk_used;
  logic [31:0] bump_at;
  logic [31:0] heap_limit;

  grant_t      grant_q[$];
  int          errors;
  int          results;
  int          reuses;
  logic [3:0]  status_mask;

  function automatic grant_t serve_request(input logic act, input logic [31:0] req,
                                           input logic [31:0] rel);
    grant_t      g;
    logic [33:0] end_at;
    logic        hit;
    int          i;
    g.addr   = '0;
    g.status = ffba_pkg::STATUS_OK;
    g.reused = 1'b0;
    hit      = 1'b0;
    if (act == ffba_pkg::ActionAlloc) begin
      // newest to oldest, first free block that is big enough, never split
      for (i = blk_used - 1; i >= 0 && !hit; i--) begin
        if (blk_free[i] && blk_size[i] >= req) begin
          blk_free[i] = 1'b0;
          g.addr      = blk_hdr[i] + HEADER_BYTES;
          g.reused    = 1'b1;
          hit         = 1'b1;
        end
      end
      if (!hit) begin
        if (blk_used >= MAX_BLOCKS) begin
          g.status = ffba_pkg::STATUS_TABLE_FULL;
        end else begin
          end_at = {2'b00, bump_at} + 34'(HEADER_BYTES) + {2'b00, req};
          if (end_at > {2'b00, heap_limit}) begin
            g.status = ffba_pkg::STATUS_HEAP_FULL;
          end else begin
            blk_hdr[blk_used]  = bump_at;
            blk_size[blk_used] = req;
            blk_free[blk_used] = 1'b0;
            blk_used++;
            g.addr  = bump_at + HEADER_BYTES;
            bump_at = end_at[31:0];
          end
        end
      end
    end else begin
      for (i = blk_used - 1; i >= 0 && !hit; i--) begin
        if ({2'b00, blk_hdr[i]} + 34'(HEADER_BYTES) == {2'b00, rel}) begin
          blk_free[i] = 1'b1;
          hit         = 1'b1;
        end
      end
      if (!hit) begin
        g.status = ffba_pkg::STATUS_UNKNOWN_ADDR;
      end
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want;
    grant_t seen;
    if (!rst_ni) begin
      blk_used    = 0;
      bump_at     = '0;
      heap_limit  = ffba_pkg::HeapBytesReset;
      foreach (blk_free[i]) blk_free[i] = 1'b0;
      grant_q.delete();
      errors      = 0;
      results     = 0;
      reuses      = 0;
      status_mask = '0;
      fail_count_o   <= 0;
      grants_due_o   <= 0;
      results_seen_o <= 0;
      reuse_seen_o   <= 0;
      status_mask_o  <= '0;
    end else begin
      if (heap_bytes_we_i) begin
        heap_limit = heap_bytes_i;
      end
      if (in_valid_i && !in_stall_i) begin
        grant_q.push_back(serve_request(action_i, request_bytes_i, release_address_i));
      end
      if (out_valid_i && !out_stall_i) begin
        seen.addr   = user_address_i;
        seen.status = ffba_pkg::status_e'(status_i);
        seen.reused = reused_i;
        results++;
        if (reused_i === 1'b1) reuses++;
        if (!$isunknown(status_i)) status_mask[status_i] = 1'b1;
        if (grant_q.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("ffba_scoreboard: unexpected result: addr %h status %0d reused %0d",
                     seen.addr, seen.status, seen.reused);
          end
        end else begin
          want = grant_q.pop_front();
          if (want !== seen) begin
            errors++;
            if (errors <= 10) begin
              $display("ffba_scoreboard: mismatch at %0t: expected addr %h status %0d %s",
                       $realtime, want.addr, want.status, "reused", want.reused);
              $display("ffba_scoreboard:   got addr %h status %0d reused %0d",
                       seen.addr, seen.status, seen.reused);
            end
          end
        end
      end
      fail_count_o   <= errors;
      grants_due_o   <= grant_q.size();
      results_seen_o <= results;
      reuse_seen_o   <= reuses;
      status_mask_o  <= status_mask;
    end
  end

endmodule

// File: tb/testbench.sv
// stimulus, clock, reset and verdict for the first-fit block allocator
`timescale 1ns / 1ps
module testbench;

  localparam int SettleCycles = int'(ffba_pkg::MaxBlocksDefault) + 8;
  localparam int HoldCycles   = 300;
  localparam int IdleLimit    = 5000;
  localparam int PhaseItems   = 225;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        heap_we;
  logic [31:0] heap_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [31:0] request_bytes;
  logic [31:0] release_address;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] user_address;
  logic [1:0]  status;
  logic        reused;

  int          fail_count;
  int          grants_due;
  int          results_seen;
  int          reuse_seen;
  logic [3:0]  status_mask;

  int          tx_idle_pct;
  int          rx_stall_pct;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  logic [31:0] handed_out[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  first_fit_block_allocator_top u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .heap_bytes_we_i   (heap_we),
    .heap_bytes_i      (heap_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .action_i          (action),
    .request_bytes_i   (request_bytes),
    .release_address_i (release_address),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .user_address_o    (user_address),
    .status_o          (status),
    .reused_o          (reused)
  );

  ffba_scoreboard u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .heap_bytes_we_i   (heap_we),
    .heap_bytes_i      (heap_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .action_i          (action),
    .request_bytes_i   (request_bytes),
    .release_address_i (release_address),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .user_address_i    (user_address),
    .status_i          (status),
    .reused_i          (reused),
    .fail_count_o      (fail_count),
    .grants_due_o      (grants_due),
    .results_seen_o    (results_seen),
    .reuse_seen_o      (reuse_seen),
    .status_mask_o     (status_mask)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HoldCycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // keep recent payload offsets so that most frees hit a live block
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && status == ffba_pkg::STATUS_OK
        && user_address != '0) begin
      handed_out.push_back(user_address);
      if (handed_out.size() > 96) void'(handed_out.pop_front());
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  task automatic send_request(input logic act, input logic [31:0] req,
                              input logic [31:0] rel);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid        <= 1'b1;
    action          <= act;
    request_bytes   <= req;
    release_address <= rel;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (grants_due != 0);
  endtask

  task automatic set_heap(input logic [31:0] bytes);
    drain();
    // quiet gap before the register write
    repeat (SettleCycles) @(posedge clk);
    heap_we    <= 1'b1;
    heap_wdata <= bytes;
    @(posedge clk);
    heap_we    <= 1'b0;
  endtask

  task automatic random_request(input int free_pct);
    logic        act;
    logic [31:0] req;
    logic [31:0] rel;
    int          pick;
    act  = ($urandom_range(99) < free_pct) ? ffba_pkg::ActionFree : ffba_pkg::ActionAlloc;
    pick = $urandom_range(99);
    req  = $urandom;
    rel  = $urandom;
    if (act == ffba_pkg::ActionAlloc) begin
      if (pick < 10)      req = '0;
      else if (pick < 55) req = $urandom_range(64);
      else if (pick < 80) req = $urandom_range(1024, 65);
      else if (pick < 95) req = $urandom_range(20000);
    end else if (handed_out.size() != 0 && pick < 70) begin
      rel = handed_out[$urandom_range(handed_out.size() - 1)];
      // near miss around a live offset
      if (pick >= 60) rel = rel + 32'($urandom_range(16)) - 32'd8;
    end
    send_request(act, req, rel);
  endtask

  task automatic run_phase(input logic [31:0] heap, input int tx_pct, input int rx_pct,
                           input int free_pct, input bit squeeze);
    int k;
    set_heap(heap);
    tx_idle_pct  = tx_pct;
    rx_stall_pct <= rx_pct;
    for (k = 0; k < PhaseItems; k++) begin
      if (squeeze && k == PhaseItems / 3) begin
        // receiver holds off while the sender keeps pushing until the block backs up
        tx_idle_pct   = 0;
        hold_requests <= hold_requests + 1;
        repeat (24) random_request(free_pct);
        tx_idle_pct   = tx_pct;
      end
      if (squeeze && k == 2 * PhaseItems / 3) drain();
      random_request(free_pct);
    end
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    heap_we         = 1'b0;
    heap_wdata      = '0;
    in_valid        = 1'b0;
    action          = ffba_pkg::ActionAlloc;
    request_bytes   = '0;
    release_address = '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    hold_requests   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero size, reuse, double free, unknown offsets, heap edge
    send_request(ffba_pkg::ActionAlloc, 32'd0, 32'd0);
    send_request(ffba_pkg::ActionAlloc, 32'd1, 32'd0);
    send_request(ffba_pkg::ActionAlloc, 32'd100, 32'd0);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd32);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd32);
    send_request(ffba_pkg::ActionAlloc, 32'd0, 32'd0);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd49);
    send_request(ffba_pkg::ActionAlloc, 32'd50, 32'd0);
    send_request(ffba_pkg::ActionAlloc, 32'hFFFF_FFFF, 32'd0);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'hFFFF_FFFF);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd0);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd48);
    send_request(ffba_pkg::ActionAlloc, 32'd65371, 32'd0);
    send_request(ffba_pkg::ActionAlloc, 32'd0, 32'd0);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd165);
    // heap shrunk under the bump pointer: reuse still works, new blocks fail
    set_heap(32'd64);
    send_request(ffba_pkg::ActionAlloc, 32'd0, 32'd0);
    send_request(ffba_pkg::ActionAlloc, 32'd0, 32'd0);
    send_request(ffba_pkg::ActionFree, 32'd0, 32'd16);
    send_request(ffba_pkg::ActionAlloc, 32'd0, 32'd0);

    run_phase(32'd1048576, 0, 0, 30, 1'b0);
    run_phase(32'hFFFF_FFFF, 46, 0, 45, 1'b1);
    run_phase(32'd0, 0, 46, 50, 1'b0);
    run_phase(32'd70000, 33, 33, 40, 1'b0);
    run_phase(32'd65536, 0, 0, 45, 1'b0);

    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("summary: %0d results checked, %0d blocks handed out again, status codes seen %b",
             results_seen, reuse_seen, status_mask);
    $display("summary: heap sizes from zero to full range, table filled, long receiver hold-off");
    if (fail_count == 0 && grants_due == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: first_fit_block_allocator_top.f
design/ffba_pkg.sv
design/ffba_ram.sv
design/ffba_match.sv
design/first_fit_block_allocator_top.sv
design/ffba_checker.sv
tb/ffba_checker.sv
tb/testbench.sv
